>>> rtl/core/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// shared types and constants of the escape-time fractal iteration unit
// ----------------------------------------------------------------------------
package etf_pkg;

    // default number format, signed q8.24
    localparam int ETF_COORD_WIDTH = 32;
    localparam int ETF_FRAC_BITS   = 24;

    // fixed field widths
    localparam int ETF_PIX_WIDTH     = 17;
    localparam int ETF_CNT_WIDTH     = 17;
    localparam int ETF_ITER_WIDTH    = 16;
    localparam int ETF_VARIANT_WIDTH = 3;
    localparam int ETF_CFG_IDX_WIDTH = 3;

    // pixel position is a fraction over 2^16
    localparam int ETF_MAP_SHIFT = 16;
    // escape radius squared is 16 = 2^4
    localparam int ETF_ESC_LOG2  = 4;

    // formula codes, upper two bits of variant
    localparam logic [1:0] FORM_PLAIN   = 2'd0;
    localparam logic [1:0] FORM_DOUBLE  = 2'd1;
    localparam logic [1:0] FORM_PHOENIX = 2'd2;

    // configuration register indexes
    typedef enum logic [ETF_CFG_IDX_WIDTH-1:0] {
        CFG_VARIANT      = 3'd0,
        CFG_MAX_ITER     = 3'd1,
        CFG_C_REAL       = 3'd2,
        CFG_C_IMAG       = 3'd3,
        CFG_WINDOW_X_MIN = 3'd4,
        CFG_WINDOW_X_MAX = 3'd5,
        CFG_WINDOW_Y_MIN = 3'd6,
        CFG_WINDOW_Y_MAX = 3'd7
    } t_etf_cfg_idx;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_LO_X,
        S_MAP_HI_X,
        S_MAP_END_X,
        S_MAP_HI_Y,
        S_MAP_END_Y,
        S_INIT,
        S_SQ_X,
        S_SQ_Y,
        S_XY,
        S_ADD_CR,
        S_PLAIN_END,
        S_PH_X,
        S_PH_END,
        S_DONE
    } t_etf_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MAP_LO_X,
        OP_MAP_HI_X,
        OP_MAP_END_X,
        OP_MAP_HI_Y,
        OP_MAP_END_Y,
        OP_INIT,
        OP_SQ_X,
        OP_SQ_Y,
        OP_XY,
        OP_ADD_CR,
        OP_PLAIN_END,
        OP_PH_X,
        OP_PH_END,
        OP_OUT
    } t_etf_op;

    typedef struct packed {
        t_etf_op op;
        logic    cnt_inc;
    } t_etf_cmd;

    typedef struct packed {
        logic esc_now;
        logic limit_hit;
    } t_etf_stat;

endpackage

>>> rtl/core/etf_in_if.sv
// ----------------------------------------------------------------------------
// etf_in_if
// pixel position channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface etf_in_if;
    logic                                valid;
    logic                                ready;
    logic [etf_pkg::ETF_PIX_WIDTH-1:0]   pixel_x;
    logic [etf_pkg::ETF_PIX_WIDTH-1:0]   pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> rtl/core/etf_out_if.sv
// ----------------------------------------------------------------------------
// etf_out_if
// iteration result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface etf_out_if #(
    parameter int COORD_WIDTH = etf_pkg::ETF_COORD_WIDTH
);
    logic                                valid;
    logic                                ready;
    logic [etf_pkg::ETF_CNT_WIDTH-1:0]   iteration_count;
    logic signed [COORD_WIDTH-1:0]       final_real;
    logic signed [COORD_WIDTH-1:0]       final_imag;
    logic                                escaped;

    modport source (output valid, output iteration_count, output final_real,
                    output final_imag, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input final_real,
                    input final_imag, input escaped, output ready);
endinterface

>>> rtl/core/etf_ctrl.sv
// ----------------------------------------------------------------------------
// etf_ctrl
// sequencer: mapping, step micro-sequence, escape decision, output handoff
// ----------------------------------------------------------------------------
module etf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_formula,
    input  etf_pkg::t_etf_stat i_stat,
    output etf_pkg::t_etf_cmd  o_cmd
);

    etf_pkg::t_etf_state r_state, n_state;
    logic                r_check, n_check;
    logic                r_half, n_half;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etf_pkg::S_IDLE;
            r_check     <= 1'b0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_check     <= n_check;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_check       = r_check;
        n_half        = r_half;
        n_out_valid   = r_out_valid;
        o_cmd.op      = etf_pkg::OP_IDLE;
        o_cmd.cnt_inc = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            etf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = etf_pkg::OP_LOAD;
                    n_state  = etf_pkg::S_MAP_LO_X;
                end
            end
            etf_pkg::S_MAP_LO_X: begin
                o_cmd.op = etf_pkg::OP_MAP_LO_X;
                n_state  = etf_pkg::S_MAP_HI_X;
            end
            etf_pkg::S_MAP_HI_X: begin
                o_cmd.op = etf_pkg::OP_MAP_HI_X;
                n_state  = etf_pkg::S_MAP_END_X;
            end
            etf_pkg::S_MAP_END_X: begin
                o_cmd.op = etf_pkg::OP_MAP_END_X;
                n_state  = etf_pkg::S_MAP_HI_Y;
            end
            etf_pkg::S_MAP_HI_Y: begin
                o_cmd.op = etf_pkg::OP_MAP_HI_Y;
                n_state  = etf_pkg::S_MAP_END_Y;
            end
            etf_pkg::S_MAP_END_Y: begin
                o_cmd.op = etf_pkg::OP_MAP_END_Y;
                n_state  = etf_pkg::S_INIT;
            end
            etf_pkg::S_INIT: begin
                o_cmd.op = etf_pkg::OP_INIT;
                n_check  = 1'b0;
                n_half   = 1'b0;
                n_state  = etf_pkg::S_SQ_X;
            end
            etf_pkg::S_SQ_X: begin
                o_cmd.op = etf_pkg::OP_SQ_X;
                n_state  = etf_pkg::S_SQ_Y;
            end
            etf_pkg::S_SQ_Y: begin
                o_cmd.op = etf_pkg::OP_SQ_Y;
                n_state  = etf_pkg::S_XY;
            end
            etf_pkg::S_XY: begin
                o_cmd.op = etf_pkg::OP_XY;
                // decide only at an iteration boundary
                if (r_check && (i_stat.esc_now || i_stat.limit_hit)) begin
                    n_state = etf_pkg::S_DONE;
                end else begin
                    n_state = etf_pkg::S_ADD_CR;
                end
            end
            etf_pkg::S_ADD_CR: begin
                o_cmd.op = etf_pkg::OP_ADD_CR;
                if (i_formula == etf_pkg::FORM_PHOENIX) begin
                    n_state = etf_pkg::S_PH_X;
                end else begin
                    n_state = etf_pkg::S_PLAIN_END;
                end
            end
            etf_pkg::S_PH_X: begin
                o_cmd.op = etf_pkg::OP_PH_X;
                n_state  = etf_pkg::S_PH_END;
            end
            etf_pkg::S_PLAIN_END, etf_pkg::S_PH_END: begin
                if (r_state == etf_pkg::S_PH_END) begin
                    o_cmd.op = etf_pkg::OP_PH_END;
                end else begin
                    o_cmd.op = etf_pkg::OP_PLAIN_END;
                end
                // doubled formula: first half step is not an iteration
                if (i_formula == etf_pkg::FORM_DOUBLE && !r_half) begin
                    n_half  = 1'b1;
                    n_check = 1'b0;
                end else begin
                    n_half        = 1'b0;
                    n_check       = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
                n_state = etf_pkg::S_SQ_X;
            end
            etf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = etf_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = etf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = etf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == etf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // the output register is only reloaded once its word is gone
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == etf_pkg::OP_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while still held");

    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == etf_pkg::OP_OUT) |=> r_out_valid)
        else $error("loaded result not presented");

    a_half_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_formula == etf_pkg::FORM_DOUBLE))
        else $error("half step pending outside doubled formula");

    a_inc_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> (r_state == etf_pkg::S_PLAIN_END || r_state == etf_pkg::S_PH_END))
        else $error("iteration counted outside a step end");

endmodule

>>> rtl/core/etf_dp.sv
// ----------------------------------------------------------------------------
// etf_dp
// datapath: one shared signed multiplier, saturating adder, iterate registers
// ----------------------------------------------------------------------------
module etf_dp #(
    parameter int COORD_WIDTH = etf_pkg::ETF_COORD_WIDTH,
    parameter int FRAC_BITS   = etf_pkg::ETF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  etf_pkg::t_etf_cmd                     i_cmd,
    output etf_pkg::t_etf_stat                    o_stat,
    input  logic [etf_pkg::ETF_PIX_WIDTH-1:0]     i_pixel_x,
    input  logic [etf_pkg::ETF_PIX_WIDTH-1:0]     i_pixel_y,
    input  logic                                  i_julia,
    input  logic [etf_pkg::ETF_ITER_WIDTH-1:0]    i_max_iteration,
    input  logic signed [COORD_WIDTH-1:0]         i_c_real,
    input  logic signed [COORD_WIDTH-1:0]         i_c_imag,
    input  logic signed [COORD_WIDTH-1:0]         i_window_x_min,
    input  logic signed [COORD_WIDTH-1:0]         i_window_x_max,
    input  logic signed [COORD_WIDTH-1:0]         i_window_y_min,
    input  logic signed [COORD_WIDTH-1:0]         i_window_y_max,
    output logic [etf_pkg::ETF_CNT_WIDTH-1:0]     o_iteration_count,
    output logic signed [COORD_WIDTH-1:0]         o_final_real,
    output logic signed [COORD_WIDTH-1:0]         o_final_imag,
    output logic                                  o_escaped
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * COORD_WIDTH;
    localparam int L   = 2 * COORD_WIDTH + 2;
    localparam int PXW = etf_pkg::ETF_PIX_WIDTH;
    localparam int RW  = etf_pkg::ETF_PIX_WIDTH + 1;
    localparam int CW  = etf_pkg::ETF_CNT_WIDTH;
    localparam logic signed [RW-1:0] MAP_ONE = RW'(1) << etf_pkg::ETF_MAP_SHIFT;
    localparam logic [PW:0] ESC_LIMIT =
        (2 * COORD_WIDTH + 1)'(1) << (etf_pkg::ETF_ESC_LOG2 + 2 * FRAC_BITS);
    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [L-1:0] f_ext(input logic signed [W-1:0] a);
        f_ext = {{(L-W){a[W-1]}}, a};
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [L-1:0] v);
        logic signed [W-1:0] r;
        if ((&v[L-1:W-1]) || !(|v[L-1:W-1])) begin
            r = v[W-1:0];
        end else if (v[L-1]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        f_sat = r;
    endfunction

    // product shifted right (floor) and saturated
    function automatic logic signed [W-1:0] f_satq(input logic signed [PW-1:0] p,
                                                   input int sh);
        logic signed [L-1:0] e;
        e = {{(L-PW){p[PW-1]}}, p};
        e = e >>> sh;
        f_satq = f_sat(e);
    endfunction

    logic [PXW-1:0]         r_tx, r_ty;
    logic signed [W-1:0]    r_x, r_y, r_px, r_py, r_cr, r_ci, r_ta, r_tb;
    logic signed [PW-1:0]   r_prod, r_sum;
    logic [PW-1:0]          r_xx;
    logic                   r_esc;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_out_count;
    logic signed [W-1:0]    r_out_real, r_out_imag;
    logic                   r_out_esc;

    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]   n_prod;
    logic signed [RW-1:0]   rest_x, rest_y;
    logic signed [W-1:0]    rest_x_w, rest_y_w, tx_w, ty_w;
    logic signed [L-1:0]    map_total;
    logic signed [W-1:0]    map_res;
    logic [PW:0]            sq_sum;

    assign rest_x   = MAP_ONE - $signed({1'b0, r_tx});
    assign rest_y   = MAP_ONE - $signed({1'b0, r_ty});
    assign rest_x_w = {{(W-RW){rest_x[RW-1]}}, rest_x};
    assign rest_y_w = {{(W-RW){rest_y[RW-1]}}, rest_y};
    assign tx_w     = $signed({{(W-PXW){1'b0}}, r_tx});
    assign ty_w     = $signed({{(W-PXW){1'b0}}, r_ty});

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            etf_pkg::OP_MAP_LO_X: begin
                mul_a = i_window_x_min;
                mul_b = rest_x_w;
            end
            etf_pkg::OP_MAP_HI_X: begin
                mul_a = i_window_x_max;
                mul_b = tx_w;
            end
            etf_pkg::OP_MAP_END_X: begin
                mul_a = i_window_y_min;
                mul_b = rest_y_w;
            end
            etf_pkg::OP_MAP_HI_Y: begin
                mul_a = i_window_y_max;
                mul_b = ty_w;
            end
            etf_pkg::OP_SQ_X: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            etf_pkg::OP_SQ_Y: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            etf_pkg::OP_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            etf_pkg::OP_ADD_CR: begin
                mul_a = r_ci;
                mul_b = r_px;
            end
            etf_pkg::OP_PH_X: begin
                mul_a = r_ci;
                mul_b = r_py;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    assign map_total = ($signed({{(L-PW){r_sum[PW-1]}}, r_sum})
                        + $signed({{(L-PW){r_prod[PW-1]}}, r_prod}))
                       >>> etf_pkg::ETF_MAP_SHIFT;
    assign map_res   = f_sat(map_total);

    // exact |z|^2 of the current iterate: x*x held, y*y in the product register
    assign sq_sum           = {1'b0, r_xx} + {1'b0, r_prod};
    assign o_stat.esc_now   = (sq_sum >= ESC_LIMIT);
    assign o_stat.limit_hit = (r_count > {1'b0, i_max_iteration});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_cmd.op == etf_pkg::OP_INIT) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (i_cmd.op)
            etf_pkg::OP_LOAD: begin
                r_tx <= i_pixel_x;
                r_ty <= i_pixel_y;
            end
            etf_pkg::OP_MAP_HI_X, etf_pkg::OP_MAP_HI_Y: begin
                r_sum <= r_prod;
            end
            etf_pkg::OP_MAP_END_X: begin
                r_x <= map_res;
            end
            etf_pkg::OP_MAP_END_Y: begin
                r_y <= map_res;
            end
            etf_pkg::OP_INIT: begin
                if (i_julia) begin
                    r_cr <= i_c_real;
                    r_ci <= i_c_imag;
                    r_px <= r_x;
                    r_py <= r_y;
                end else begin
                    r_cr <= r_x;
                    r_ci <= r_y;
                    r_px <= '0;
                    r_py <= '0;
                end
            end
            etf_pkg::OP_SQ_Y: begin
                r_xx <= r_prod;
                r_ta <= f_satq(r_prod, FRAC_BITS);
            end
            etf_pkg::OP_XY: begin
                r_esc <= o_stat.esc_now;
                r_ta  <= f_sat(f_ext(r_ta) - f_ext(f_satq(r_prod, FRAC_BITS)));
            end
            etf_pkg::OP_ADD_CR: begin
                r_ta <= f_sat(f_ext(r_ta) + f_ext(r_cr));
                r_tb <= f_satq(r_prod, FRAC_BITS - 1);
            end
            etf_pkg::OP_PLAIN_END: begin
                r_x <= r_ta;
                r_y <= f_sat(f_ext(r_tb) + f_ext(r_ci));
            end
            etf_pkg::OP_PH_X: begin
                r_ta <= f_sat(f_ext(r_ta) + f_ext(f_satq(r_prod, FRAC_BITS)));
            end
            etf_pkg::OP_PH_END: begin
                r_x  <= r_ta;
                r_y  <= f_sat(f_ext(r_tb) + f_ext(f_satq(r_prod, FRAC_BITS)));
                r_px <= r_x;
                r_py <= r_y;
            end
            etf_pkg::OP_OUT: begin
                r_out_count <= r_count;
                r_out_real  <= r_x;
                r_out_imag  <= r_y;
                r_out_esc   <= r_esc;
            end
            default: begin
            end
        endcase
    end

    assign o_iteration_count = r_out_count;
    assign o_final_real      = r_out_real;
    assign o_final_imag      = r_out_imag;
    assign o_escaped         = r_out_esc;

    // at least one iteration always ran before a result is loaded
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == etf_pkg::OP_OUT) |-> (r_count != '0))
        else $error("result loaded with zero iterations");

    // count only moves at init or step end
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != etf_pkg::OP_INIT && !i_cmd.cnt_inc) |=> $stable(r_count))
        else $error("iteration count changed without a command");

endmodule

>>> rtl/core/escape_time_fractal_iteration_unit.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iteration_unit
// mandelbrot / julia / phoenix escape-time iteration on one pixel per word
// ----------------------------------------------------------------------------
// Each input word is a pixel position (pixel_x, pixel_y as value/65536) that
// is mapped into the configured complex window, then iterated z = z^2 + c
// (plain, doubled or phoenix) until |z|^2 >= 16 or the count passes
// max_iteration; one result word gives the count, the saturated final z in
// signed fixed point and the escape flag. All products go through a single
// shared signed multiplier, one product per clock. An item runs through
// mapping and setup, then the steps of the chosen formula until the escape
// or count test ends them, then hands its result over. The unit works on
// one pixel at a time; the next pixel is taken as soon as the result sits
// in the output register, and the finished result waits there until the
// sink takes it.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data and must only change while no pixel is in flight.

module escape_time_fractal_iteration_unit #(
    parameter int COORD_WIDTH = etf_pkg::ETF_COORD_WIDTH,
    parameter int FRAC_BITS   = etf_pkg::ETF_FRAC_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_we,
    input  logic [etf_pkg::ETF_CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                   i_cfg_data,
    // pixel in, result out
    etf_in_if.sink                                   i_pix,
    etf_out_if.source                                o_res
);

    localparam int W = COORD_WIDTH;

    // reset window: x in [-2, 1], y in [-1.5, 1.5]
    localparam logic signed [W-1:0] RST_X_MIN = -(W'(2) << FRAC_BITS);
    localparam logic signed [W-1:0] RST_X_MAX = W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0] RST_Y_MIN = -(W'(3) << (FRAC_BITS - 1));
    localparam logic signed [W-1:0] RST_Y_MAX = W'(3) << (FRAC_BITS - 1);
    localparam logic [etf_pkg::ETF_ITER_WIDTH-1:0] RST_MAX_ITER = 16'd255;

    // configuration registers
    logic [etf_pkg::ETF_VARIANT_WIDTH-1:0] r_variant;
    logic [etf_pkg::ETF_ITER_WIDTH-1:0]    r_max_iter;
    logic signed [W-1:0]                   r_c_real, r_c_imag;
    logic signed [W-1:0]                   r_wx_min, r_wx_max, r_wy_min, r_wy_max;

    etf_pkg::t_etf_cmd  cmd;
    etf_pkg::t_etf_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant  <= '0;
            r_max_iter <= RST_MAX_ITER;
            r_c_real   <= '0;
            r_c_imag   <= '0;
            r_wx_min   <= RST_X_MIN;
            r_wx_max   <= RST_X_MAX;
            r_wy_min   <= RST_Y_MIN;
            r_wy_max   <= RST_Y_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etf_pkg::CFG_VARIANT:      r_variant  <=
                    i_cfg_data[etf_pkg::ETF_VARIANT_WIDTH-1:0];
                etf_pkg::CFG_MAX_ITER:     r_max_iter <=
                    i_cfg_data[etf_pkg::ETF_ITER_WIDTH-1:0];
                etf_pkg::CFG_C_REAL:       r_c_real   <= $signed(i_cfg_data);
                etf_pkg::CFG_C_IMAG:       r_c_imag   <= $signed(i_cfg_data);
                etf_pkg::CFG_WINDOW_X_MIN: r_wx_min   <= $signed(i_cfg_data);
                etf_pkg::CFG_WINDOW_X_MAX: r_wx_max   <= $signed(i_cfg_data);
                etf_pkg::CFG_WINDOW_Y_MIN: r_wy_min   <= $signed(i_cfg_data);
                etf_pkg::CFG_WINDOW_Y_MAX: r_wy_max   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // sequencer: formula code is the upper variant bits, code 3 runs plain
    etf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_formula   (r_variant[2:1]),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: mapping, step arithmetic, escape test, output register
    etf_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_pixel_x         (i_pix.pixel_x),
        .i_pixel_y         (i_pix.pixel_y),
        .i_julia           (r_variant[0]),
        .i_max_iteration   (r_max_iter),
        .i_c_real          (r_c_real),
        .i_c_imag          (r_c_imag),
        .i_window_x_min    (r_wx_min),
        .i_window_x_max    (r_wx_max),
        .i_window_y_min    (r_wy_min),
        .i_window_y_max    (r_wy_max),
        .o_iteration_count (o_res.iteration_count),
        .o_final_real      (o_res.final_real),
        .o_final_imag      (o_res.final_imag),
        .o_escaped         (o_res.escaped)
    );

endmodule
